[hdl/lmsw_pkg.sv]
// ----------------------------------------------------------------------------
// lmsw_pkg: shared types and constants for the scrolling LED matrix window
// Request codes, register indexes, sequencer states and parameter defaults.
// ----------------------------------------------------------------------------
package lmsw_pkg;

  localparam int ANIM_DEPTH_DEF   = 1024;
  localparam int MAX_MATRICES_DEF = 8;

  localparam int DIGIT_ROWS = 8;      // rows of one 8x8 matrix
  localparam int COLS_PER_MATRIX = 8;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_RESTART = 2'd1,
    KIND_ADVANCE = 2'd2
  } kind_t;

  typedef enum logic {
    CFG_NUM_MATRICES = 1'b0,
    CFG_ANIM_LENGTH  = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_PREP = 2'd1,
    ST_RUN  = 2'd2
  } state_t;

endpackage

[hdl/led_matrix_scroll_window_core.sv]
// ----------------------------------------------------------------------------
// led_matrix_scroll_window_core: scrolling window over chained 8x8 matrices
// Stores a circular column animation and, per advance request, walks the
// store once per frame (row-major, farthest matrix first), stepping the read
// address with one shared wrap adder.
// ----------------------------------------------------------------------------
//  channel   signals                                       direction
//  request   start, busy, kind, load_address, load_byte    in (busy out)
//  result    strobe, frame_valid, digit_register,          out
//            led_byte, latch_after, last, still_playing
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data     in (ready out)
//
//  Load and restart requests finish in the cycle they are taken.
//  An armed advance keeps busy high while ST_PREP steps the read address out
//  to the farthest matrix, then ST_RUN does one store read per cycle on the
//  single read port; each result appears in the cycle after its read.
//  A disarmed advance gives its single result in the next cycle.
//  Synchronous reset clears position, arming and the sequencer; the store
//  holds garbage until loaded. Results cannot be stalled; cfg_ready is 1.
// ----------------------------------------------------------------------------
module led_matrix_scroll_window_core #(
  parameter int ANIM_DEPTH   = lmsw_pkg::ANIM_DEPTH_DEF,
  parameter int MAX_MATRICES = lmsw_pkg::MAX_MATRICES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [9:0]  load_address,
  input  logic [7:0]  load_byte,
  output logic        strobe,
  output logic        frame_valid,
  output logic [3:0]  digit_register,
  output logic [7:0]  led_byte,
  output logic        latch_after,
  output logic        last,
  output logic        still_playing,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);

  localparam int AW = $clog2(ANIM_DEPTH);
  localparam int LW = AW + 1;
  localparam int DW = AW + 2;
  localparam int CW = (LW > 11) ? LW : 11;

  lmsw_pkg::state_t state, state_next;

  logic [3:0]    num_matrices;
  logic [10:0]   anim_length;
  logic [AW-1:0] position;
  logic [LW-1:0] play_len;
  logic          first_pass;
  logic          armed;

  logic [AW-1:0] cur;
  logic [AW-1:0] row_base;
  logic [2:0]    n_m1;
  logic [2:0]    row, row_next;
  logic [2:0]    m_idx, m_idx_next;
  logic [2:0]    cnt, cnt_next;
  logic          play;

  logic [7:0]    anim_store [ANIM_DEPTH];
  logic [7:0]    rd_data;

  logic          accept;
  logic [3:0]    n_eff;
  logic [LW-1:0] len_eff;
  logic          restart_ok;
  logic [LW-1:0] pos_inc;
  logic [LW-1:0] pos_new;

  logic          iss;
  logic          iss_frame;
  logic          iss_latch;
  logic          iss_last;
  logic [3:0]    iss_digit;
  logic [AW-1:0] step_a;
  logic [DW-1:0] step_b;
  logic [DW-1:0] step_sum;
  logic [DW-1:0] step_fix;
  logic [AW-1:0] step_res;

  logic          frame_q;

  assign accept    = start && !busy;
  assign busy      = (state != lmsw_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  // Clamp the matrix count and the length into their usable ranges.
  always_comb begin
    priority if (num_matrices == 4'd0) begin
      n_eff = 4'd1;
    end else if (num_matrices > 4'(MAX_MATRICES)) begin
      n_eff = 4'(MAX_MATRICES);
    end else begin
      n_eff = num_matrices;
    end
    if (CW'(anim_length) > CW'(ANIM_DEPTH)) begin
      len_eff = LW'(ANIM_DEPTH);
    end else begin
      len_eff = LW'(anim_length);
    end
    restart_ok = (len_eff != '0) && (CW'(len_eff) > CW'({n_eff, 3'b000}));
  end

  always_comb begin
    pos_inc = LW'(position) + LW'(1);
    pos_new = (pos_inc >= play_len) ? '0 : pos_inc;
  end

  // Step the read address by +8 (prep), -8 (next matrix) or +1 (next row).
  // play_len is at least 9, so one add or subtract of it wraps the result.
  always_comb begin
    priority if (state == lmsw_pkg::ST_RUN && m_idx == 3'd0) begin
      step_a = row_base;
      step_b = DW'(1);
    end else if (state == lmsw_pkg::ST_RUN) begin
      step_a = cur;
      step_b = DW'(0) - DW'(lmsw_pkg::COLS_PER_MATRIX);
    end else begin
      step_a = cur;
      step_b = DW'(lmsw_pkg::COLS_PER_MATRIX);
    end
    step_sum = DW'(step_a) + step_b;
    if (step_sum[DW-1]) begin
      step_fix = step_sum + DW'(play_len);
    end else if (step_sum >= DW'(play_len)) begin
      step_fix = step_sum - DW'(play_len);
    end else begin
      step_fix = step_sum;
    end
    step_res = AW'(step_fix);
  end

  always_comb begin
    state_next = state;
    row_next   = row;
    m_idx_next = m_idx;
    cnt_next   = cnt;
    iss        = 1'b0;
    iss_frame  = 1'b0;
    iss_latch  = 1'b0;
    iss_last   = 1'b0;
    iss_digit  = 4'd0;
    unique case (state)
      lmsw_pkg::ST_IDLE: begin
        row_next   = 3'd0;
        m_idx_next = 3'(n_eff - 4'd1);
        cnt_next   = 3'(n_eff - 4'd1);
        if (accept && kind == lmsw_pkg::KIND_ADVANCE) begin
          if (armed) begin
            state_next = (n_eff == 4'd1) ? lmsw_pkg::ST_RUN : lmsw_pkg::ST_PREP;
          end else begin
            iss      = 1'b1;
            iss_last = 1'b1;
          end
        end
      end
      lmsw_pkg::ST_PREP: begin
        cnt_next = cnt - 3'd1;
        if (cnt == 3'd1) begin
          state_next = lmsw_pkg::ST_RUN;
        end
      end
      lmsw_pkg::ST_RUN: begin
        iss       = 1'b1;
        iss_frame = 1'b1;
        iss_digit = {1'b0, row} + 4'd1;
        iss_latch = (m_idx == 3'd0);
        iss_last  = (m_idx == 3'd0) && (row == 3'(lmsw_pkg::DIGIT_ROWS - 1));
        if (m_idx == 3'd0) begin
          m_idx_next = n_m1;
          if (row == 3'(lmsw_pkg::DIGIT_ROWS - 1)) begin
            state_next = lmsw_pkg::ST_IDLE;
          end else begin
            row_next = row + 3'd1;
          end
        end else begin
          m_idx_next = m_idx - 3'd1;
        end
      end
      default: state_next = lmsw_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= lmsw_pkg::ST_IDLE;
      num_matrices <= 4'd1;
      anim_length  <= 11'd0;
      position     <= '0;
      play_len     <= '0;
      first_pass   <= 1'b1;
      armed        <= 1'b0;
      strobe       <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= iss;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          lmsw_pkg::CFG_NUM_MATRICES: num_matrices <= cfg_data[3:0];
          lmsw_pkg::CFG_ANIM_LENGTH:  anim_length  <= cfg_data;
          default: ;
        endcase
      end
      if (accept && kind == lmsw_pkg::KIND_RESTART) begin
        armed <= restart_ok;
        if (restart_ok) begin
          play_len   <= len_eff;
          position   <= '0;
          first_pass <= 1'b1;
        end
      end
      // Step the position at the start of an armed advance.
      if (accept && kind == lmsw_pkg::KIND_ADVANCE && armed) begin
        position <= AW'(pos_new);
        if (pos_new == LW'(1)) begin
          first_pass <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    row   <= row_next;
    m_idx <= m_idx_next;
    cnt   <= cnt_next;
    if (accept && kind == lmsw_pkg::KIND_ADVANCE) begin
      cur      <= position;
      row_base <= position;
      n_m1     <= 3'(n_eff - 4'd1);
      play     <= !armed || !((pos_new == LW'(1)) && !first_pass);
    end else if (state == lmsw_pkg::ST_PREP) begin
      cur      <= step_res;
      row_base <= step_res;
    end else if (state == lmsw_pkg::ST_RUN) begin
      cur <= step_res;
      if (m_idx == 3'd0) begin
        row_base <= step_res;
      end
    end
    if (iss) begin
      frame_q        <= iss_frame;
      digit_register <= iss_digit;
      latch_after    <= iss_latch;
      last           <= iss_last;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kind == lmsw_pkg::KIND_LOAD &&
        32'(load_address) < 32'(ANIM_DEPTH)) begin
      anim_store[AW'(load_address)] <= load_byte;
    end
    if (iss_frame) begin
      rd_data <= anim_store[cur];
    end
  end

  assign frame_valid   = frame_q;
  assign led_byte      = frame_q ? rd_data : 8'd0;
  assign still_playing = frame_q ? play : 1'b1;

  a_last_latches: assert property (@(posedge clk) disable iff (rst)
    strobe && last && frame_valid |-> latch_after)
    else $error("last frame of an advance not latched");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    strobe && !frame_valid |-> last && still_playing && led_byte == 8'd0)
    else $error("empty result malformed");

  a_run_emits: assert property (@(posedge clk) disable iff (rst)
    state == lmsw_pkg::ST_RUN |=> strobe && frame_valid)
    else $error("frame read without a result");

  a_end_of_run: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> strobe && last)
    else $error("advance ended without its final result");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    strobe && frame_valid |-> digit_register != 4'd0 && digit_register <= 4'd8)
    else $error("digit register out of range");

endmodule

[sim/tb_led_matrix_scroll_window_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_matrix_scroll_window_core: self-checking bench for the scroll window
// Preloads the column store, walks a directed table (disarmed advances, short
// restarts, length and matrix-count extremes, wrap to the stop flag), then
// runs random episodes of config, restart, load and advance requests. Every
// frame is checked against an in-bench model of the scrolling window.
// ----------------------------------------------------------------------------
module tb_led_matrix_scroll_window_core;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 16;
  localparam int QUIET_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 50;
  localparam int PRINT_CAP     = 30;
  localparam int PRELOAD_COLS  = 80;

  typedef struct packed {
    logic       frame_valid;
    logic [3:0] digit_register;
    logic [7:0] led_byte;
    logic       latch_after;
    logic       last;
    logic       still_playing;
  } frame_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [9:0] column;
    logic [7:0] column_bits;
  } req_t;

  typedef enum logic {ROW_REQUEST, ROW_CONFIG} row_op_t;

  typedef struct packed {
    row_op_t            op;
    req_t               req;
    int                 reps;
    bit                 idle_typed;
    lmsw_pkg::cfg_reg_t cfg_idx;
    logic [10:0]        cfg_val;
  } plan_row_t;

  localparam frame_t IDLE_FRAME = '{frame_valid: 1'b0, digit_register: 4'd0,
                                    led_byte: 8'd0, latch_after: 1'b0,
                                    last: 1'b1, still_playing: 1'b1};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = lmsw_pkg::KIND_LOAD;
  logic [9:0]  load_address = '0;
  logic [7:0]  load_byte = '0;
  logic        strobe;
  logic        frame_valid;
  logic [3:0]  digit_register;
  logic [7:0]  led_byte;
  logic        latch_after;
  logic        last;
  logic        still_playing;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  lmsw_pkg::cfg_reg_t cfg_index = lmsw_pkg::CFG_NUM_MATRICES;
  logic [10:0] cfg_data = '0;

  // model state
  logic [7:0]  column_store [lmsw_pkg::ANIM_DEPTH_DEF];
  int          scroll_pos = 0;
  bit          first_lap = 1'b1;
  bit          armed = 1'b0;
  int          latched_len = 0;
  logic [3:0]  cfg_matrices = 4'd1;
  logic [10:0] cfg_length = 11'd0;

  frame_t      model_out [$];
  frame_t      frames_due [$];
  plan_row_t   plan [$];
  frame_t      seen_frame;
  frame_t      due_frame;
  int          mismatches = 0;
  int          results_seen = 0;
  int          quiet_cycles = 0;
  int          burst_left = 0;
  bit          steady = 1'b0;

  led_matrix_scroll_window_core uut (
    .clk(clk), .rst(rst),
    .start(start), .busy(busy),
    .kind(kind), .load_address(load_address), .load_byte(load_byte),
    .strobe(strobe), .frame_valid(frame_valid), .digit_register(digit_register),
    .led_byte(led_byte), .latch_after(latch_after), .last(last),
    .still_playing(still_playing),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int visible_matrices(input logic [3:0] v);
    if (v == 4'd0) return 1;
    if (v > lmsw_pkg::MAX_MATRICES_DEF) return lmsw_pkg::MAX_MATRICES_DEF;
    return int'(v);
  endfunction

  // Frames one request produces, left in model_out; state steps as the block's.
  function automatic void predict_frames(input req_t r);
    int len, n, first_col, idx, row, m;
    bit play;
    frame_t f;
    model_out.delete();
    case (r.kind)
      lmsw_pkg::KIND_LOAD: column_store[r.column] = r.column_bits;
      lmsw_pkg::KIND_RESTART: begin
        len = (cfg_length > lmsw_pkg::ANIM_DEPTH_DEF) ? lmsw_pkg::ANIM_DEPTH_DEF
                                                      : int'(cfg_length);
        if (len == 0 ||
            len <= visible_matrices(cfg_matrices) * lmsw_pkg::COLS_PER_MATRIX) begin
          armed = 1'b0;
        end else begin
          armed = 1'b1;
          latched_len = len;
          scroll_pos = 0;
          first_lap = 1'b1;
        end
      end
      lmsw_pkg::KIND_ADVANCE: begin
        if (!armed || latched_len == 0) begin
          model_out.push_back(IDLE_FRAME);
        end else begin
          n = visible_matrices(cfg_matrices);
          len = latched_len;
          first_col = scroll_pos % len;
          play = 1'b1;
          scroll_pos = first_col + 1;
          if (scroll_pos >= len) scroll_pos = 0;
          // column 1 again after the first lap ends play
          if (scroll_pos == 1) begin
            if (first_lap) first_lap = 1'b0;
            else play = 1'b0;
          end
          for (row = 0; row < lmsw_pkg::DIGIT_ROWS; row++) begin
            for (m = n; m > 0; m--) begin
              idx = (first_col + (m - 1) * lmsw_pkg::COLS_PER_MATRIX + row) % len;
              f.frame_valid = 1'b1;
              f.digit_register = 4'(row + 1);
              f.led_byte = column_store[idx];
              f.latch_after = (m == 1);
              f.last = (row == lmsw_pkg::DIGIT_ROWS - 1) && (m == 1);
              f.still_playing = play;
              model_out.push_back(f);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int next_burst();
    return steady ? 1000000 : $urandom_range(1, 8);
  endfunction

  function automatic req_t random_request(input logic [1:0] k);
    req_t r;
    r.kind = k;
    r.column = 10'($urandom_range(0, lmsw_pkg::ANIM_DEPTH_DEF - 1));
    r.column_bits = 8'($urandom_range(0, 255));
    return r;
  endfunction

  function automatic void add_request(input logic [1:0] k, input int col,
                                      input int bits, input int reps, input bit typed);
    plan_row_t p;
    p = '0;
    p.op = ROW_REQUEST;
    p.req = '{kind: k, column: 10'(col), column_bits: 8'(bits)};
    p.reps = reps;
    p.idle_typed = typed;
    plan.push_back(p);
  endfunction

  function automatic void add_config(input lmsw_pkg::cfg_reg_t idx, input int val);
    plan_row_t p;
    p = '0;
    p.op = ROW_CONFIG;
    p.cfg_idx = idx;
    p.cfg_val = 11'(val);
    plan.push_back(p);
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("[%0t] MISMATCH %s", $realtime, what);
  endtask

  task automatic send_request(input req_t r, input bit typed);
    @(negedge clk);
    start <= 1'b1;
    kind <= r.kind;
    load_address <= r.column;
    load_byte <= r.column_bits;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_frames(r);
    if (typed) frames_due.push_back(IDLE_FRAME);
    else foreach (model_out[i]) frames_due.push_back(model_out[i]);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat ($urandom_range(0, 11)) @(negedge clk);
      burst_left = next_burst();
    end
  endtask

  // Drop start, then hold until every expected frame is in and busy is low.
  task automatic drain_results(input int extra);
    if (start) begin
      @(negedge clk);
      start <= 1'b0;
    end
    burst_left = next_burst();
    while (frames_due.size() != 0 || busy) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_cfg(input lmsw_pkg::cfg_reg_t idx, input logic [10:0] val);
    drain_results(SETTLE_CYCLES);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == lmsw_pkg::CFG_NUM_MATRICES) cfg_matrices = val[3:0];
    else cfg_length = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && strobe) begin
      seen_frame = {frame_valid, digit_register, led_byte, latch_after, last,
                    still_playing};
      if (frames_due.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected",
                                  results_seen));
      end else begin
        due_frame = frames_due.pop_front();
        if (seen_frame !== due_frame)
          report_mismatch($sformatf(
            "result %0d: got v=%b dig=%0d led=%h latch=%b last=%b play=%b, want v=%b dig=%0d led=%h latch=%b last=%b play=%b",
            results_seen, seen_frame.frame_valid, seen_frame.digit_register,
            seen_frame.led_byte, seen_frame.latch_after, seen_frame.last,
            seen_frame.still_playing, due_frame.frame_valid, due_frame.digit_register,
            due_frame.led_byte, due_frame.latch_after, due_frame.last,
            due_frame.still_playing));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("[%0t] watchdog: no request or result for %0d cycles, %0d frames pending",
               $realtime, QUIET_LIMIT, frames_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    req_t        r;
    int          random_done;
    int          sel;
    int          wsel;
    int          vis;
    logic [3:0]  n_val;
    logic [10:0] n_data;
    logic [10:0] len_val;

    random_done = 0;
    burst_left = next_burst();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // An advance right after reset must see playback disarmed.
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 1, 1);
    // Fill every column that an armed length in this run can reach.
    for (int a = 0; a < PRELOAD_COLS; a++) begin
      r = random_request(lmsw_pkg::KIND_LOAD);
      add_request(lmsw_pkg::KIND_LOAD, a, int'(r.column_bits), 1, 0);
    end

    // directed table
    add_request(KIND_UNUSED, 1023, 255, 1, 0);
    add_request(lmsw_pkg::KIND_RESTART, 0, 0, 1, 0);   // length zero: stay disarmed
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 1, 1);
    add_request(lmsw_pkg::KIND_LOAD, 0, 255, 1, 0);
    add_request(lmsw_pkg::KIND_LOAD, 1023, 0, 1, 0);
    add_config(lmsw_pkg::CFG_ANIM_LENGTH, 8);           // exactly one screen: too short
    add_request(lmsw_pkg::KIND_RESTART, 0, 0, 1, 0);
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 1, 1);
    add_config(lmsw_pkg::CFG_ANIM_LENGTH, 9);
    add_request(lmsw_pkg::KIND_RESTART, 0, 0, 1, 0);
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 10, 0);   // full lap plus one: play stops
    add_config(lmsw_pkg::CFG_ANIM_LENGTH, 3);           // armed length must hold
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 1, 0);
    add_request(lmsw_pkg::KIND_RESTART, 0, 0, 1, 0);
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 1, 1);
    add_config(lmsw_pkg::CFG_NUM_MATRICES, 0);
    add_config(lmsw_pkg::CFG_ANIM_LENGTH, 2047);
    add_request(lmsw_pkg::KIND_RESTART, 0, 0, 1, 0);
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 1, 0);
    add_config(lmsw_pkg::CFG_NUM_MATRICES, 15);
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 1, 0);
    add_config(lmsw_pkg::CFG_ANIM_LENGTH, 64);
    add_request(lmsw_pkg::KIND_RESTART, 0, 0, 1, 0);
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 1, 1);
    add_config(lmsw_pkg::CFG_ANIM_LENGTH, 65);
    add_request(lmsw_pkg::KIND_RESTART, 0, 0, 1, 0);
    add_request(lmsw_pkg::KIND_ADVANCE, 0, 0, 1, 0);

    foreach (plan[i]) begin
      if (plan[i].op == ROW_CONFIG) write_cfg(plan[i].cfg_idx, plan[i].cfg_val);
      else repeat (plan[i].reps) send_request(plan[i].req, plan[i].idle_typed);
    end

    // random episodes
    while (random_done < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 7);
      if (sel == 0) n_val = 4'($urandom_range(lmsw_pkg::MAX_MATRICES_DEF + 1, 15));
      else if (sel == 1) n_val = 4'd0;
      else n_val = 4'($urandom_range(1, lmsw_pkg::MAX_MATRICES_DEF));
      n_data = {($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'd0, n_val};
      vis = visible_matrices(n_val);
      // armed lengths stay inside the preloaded columns
      case ($urandom_range(0, 9))
        0: len_val = 11'd0;
        1: len_val = 11'(vis * lmsw_pkg::COLS_PER_MATRIX);
        2: len_val = 11'(PRELOAD_COLS);
        3: len_val = 11'($urandom_range(0, PRELOAD_COLS));
        default: len_val = 11'(vis * lmsw_pkg::COLS_PER_MATRIX + $urandom_range(1, 16));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      wsel = $urandom_range(0, 3);
      if (wsel != 1) write_cfg(lmsw_pkg::CFG_NUM_MATRICES, n_data);
      if (wsel != 0) write_cfg(lmsw_pkg::CFG_ANIM_LENGTH, len_val);
      burst_left = next_burst();
      // skip the restart now and then so a changed config meets armed playback
      if ($urandom_range(0, 4) != 0) begin
        send_request(random_request(lmsw_pkg::KIND_RESTART), 0);
        random_done++;
      end
      repeat ($urandom_range(8, 30)) begin
        sel = $urandom_range(0, 19);
        if (sel == 19) begin
          drain_results(0);
        end else begin
          if (sel < 13) r = random_request(lmsw_pkg::KIND_ADVANCE);
          else if (sel < 16) r = random_request(lmsw_pkg::KIND_LOAD);
          else if (sel < 18) r = random_request(lmsw_pkg::KIND_RESTART);
          else r = random_request(KIND_UNUSED);
          send_request(r, 0);
          if (r.kind != KIND_UNUSED) random_done++;
        end
      end
    end

    drain_results(TAIL_CYCLES);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
